// ===== src/cle_pkg.sv =====
package cle_pkg;

    // Control bytes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_EOT   = 8'h04;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_PLIST = 8'h10;
    localparam logic [7:0] CH_KILL  = 8'h15;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    // Result kinds
    localparam logic [2:0] KIND_ECHO  = 3'd0;
    localparam logic [2:0] KIND_ERASE = 3'd1;
    localparam logic [2:0] KIND_READ  = 3'd2;
    localparam logic [2:0] KIND_EMPTY = 3'd3;
    localparam logic [2:0] KIND_PLIST = 3'd4;

    // Request types
    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_in;
    } cle_in_t;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_char;
        logic       is_eof;
        logic       line_committed;
        logic       last;
    } cle_out_t;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_PLIST,
        CMD_KILL,
        CMD_ERASE,
        CMD_APPEND
    } cle_cmd_t;

    typedef struct packed {
        cle_cmd_t   cmd;
        logic [7:0] ch;
    } cle_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_RD_EMIT,
        ST_KILL
    } cle_state_t;

endpackage

// ===== src/cle_ram.sv =====
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/cle_front.sv =====
module cle_front (
    input  logic                req_valid,
    output logic                req_stall,
    input  cle_pkg::cle_in_t    req,
    input  logic                q_full,
    output logic                q_push,
    output cle_pkg::cle_entry_t q_entry
);

    import cle_pkg::*;

    logic drop;

    // NUL bytes are taken and discarded here
    assign drop      = (req.req_type == REQ_CHAR) && (req.char_in == CH_NUL);
    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full && !drop;

    always_comb
    begin
        q_entry.ch  = req.char_in;
        q_entry.cmd = CMD_APPEND;
        if (req.req_type == REQ_READ)
        begin
            q_entry.cmd = CMD_READ;
        end
        else if (req.char_in == CH_PLIST)
        begin
            q_entry.cmd = CMD_PLIST;
        end
        else if (req.char_in == CH_KILL)
        begin
            q_entry.cmd = CMD_KILL;
        end
        else if (req.char_in inside {CH_BS, CH_DEL})
        begin
            q_entry.cmd = CMD_ERASE;
        end
        else if (req.char_in == CH_CR)
        begin
            q_entry.ch = CH_LF;
        end
    end

endmodule

// ===== src/cle_fifo.sv =====
module cle_fifo #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  cle_pkg::cle_entry_t push_entry,
    output logic                full,
    output logic                q_valid,
    input  logic                pop,
    output cle_pkg::cle_entry_t q_entry
);

    import cle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cle_entry_t    slots [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/cle_back.sv =====
module cle_back #(
    parameter int BUFFER_DEPTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  cle_pkg::cle_entry_t             q_entry,
    output logic                            q_pop,
    output logic                            we,
    output logic [$clog2(BUFFER_DEPTH)-1:0] waddr,
    output logic [7:0]                      wdata,
    output logic                            re,
    output logic [$clog2(BUFFER_DEPTH)-1:0] raddr,
    input  logic [7:0]                      rdata,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output cle_pkg::cle_out_t               rsp
);

    import cle_pkg::*;

    localparam int IDX_W   = $clog2(BUFFER_DEPTH);
    localparam int PTR_W   = $clog2(2 * BUFFER_DEPTH);
    localparam int FILL_W  = PTR_W + 1;
    localparam int PTR_MOD = 2 * BUFFER_DEPTH;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(PTR_MOD - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(PTR_MOD - 1) : p - 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] ptr_idx(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] t;
        t = (p >= PTR_W'(BUFFER_DEPTH)) ? p - PTR_W'(BUFFER_DEPTH) : p;
        return t[IDX_W-1:0];
    endfunction

    function automatic logic [FILL_W-1:0] ptr_dist(input logic [PTR_W-1:0] hi,
                                                   input logic [PTR_W-1:0] lo);
        return (hi >= lo) ? FILL_W'(hi) - FILL_W'(lo)
                          : FILL_W'(hi) + FILL_W'(PTR_MOD) - FILL_W'(lo);
    endfunction

    cle_state_t       state_reg, state_next;
    logic [PTR_W-1:0] read_ptr_reg, read_ptr_next;
    logic [PTR_W-1:0] commit_ptr_reg, commit_ptr_next;
    logic [PTR_W-1:0] edit_ptr_reg, edit_ptr_next;
    logic             rsp_valid_reg;
    cle_out_t         rsp_reg;

    logic             can_emit;
    logic             emit;
    cle_out_t         emit_data;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] pending;
    logic [PTR_W-1:0] edit_inc;
    logic [PTR_W-1:0] edit_dec;

    assign can_emit = !rsp_valid_reg || !rsp_stall;
    assign fill     = ptr_dist(edit_ptr_reg, read_ptr_reg);
    assign pending  = ptr_dist(edit_ptr_reg, commit_ptr_reg);
    assign edit_inc = ptr_inc(edit_ptr_reg);
    assign edit_dec = ptr_dec(edit_ptr_reg);

    assign waddr = ptr_idx(edit_ptr_reg);
    assign wdata = q_entry.ch;
    assign raddr = ptr_idx(read_ptr_reg);

    always_comb
    begin
        state_next      = state_reg;
        read_ptr_next   = read_ptr_reg;
        commit_ptr_next = commit_ptr_reg;
        edit_ptr_next   = edit_ptr_reg;
        q_pop           = 1'b0;
        we              = 1'b0;
        re              = 1'b0;
        emit            = 1'b0;
        emit_data       = '0;
        emit_data.last  = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && can_emit)
                begin
                    q_pop = 1'b1;
                    case (q_entry.cmd)
                        CMD_READ:
                        begin
                            if (read_ptr_reg == commit_ptr_reg)
                            begin
                                emit               = 1'b1;
                                emit_data.out_kind = KIND_EMPTY;
                            end
                            else
                            begin
                                re         = 1'b1;
                                state_next = ST_RD_WAIT;
                            end
                        end
                        CMD_PLIST:
                        begin
                            emit               = 1'b1;
                            emit_data.out_kind = KIND_PLIST;
                        end
                        CMD_KILL:
                        begin
                            if (edit_ptr_reg != commit_ptr_reg)
                            begin
                                state_next = ST_KILL;
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (edit_ptr_reg != commit_ptr_reg)
                            begin
                                edit_ptr_next      = edit_dec;
                                emit               = 1'b1;
                                emit_data.out_kind = KIND_ERASE;
                            end
                        end
                        CMD_APPEND:
                        begin
                            if (fill < FILL_W'(BUFFER_DEPTH))
                            begin
                                we                 = 1'b1;
                                edit_ptr_next      = edit_inc;
                                emit               = 1'b1;
                                emit_data.out_kind = KIND_ECHO;
                                emit_data.out_char = q_entry.ch;
                                // LF, EOT or the last free slot commits the line
                                if ((q_entry.ch == CH_LF) || (q_entry.ch == CH_EOT) ||
                                    (fill == FILL_W'(BUFFER_DEPTH - 1)))
                                begin
                                    commit_ptr_next          = edit_inc;
                                    emit_data.line_committed = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_RD_EMIT;
            end
            ST_RD_EMIT:
            begin
                if (can_emit)
                begin
                    emit               = 1'b1;
                    emit_data.out_kind = KIND_READ;
                    emit_data.out_char = rdata;
                    emit_data.is_eof   = (rdata == CH_EOT);
                    read_ptr_next      = ptr_inc(read_ptr_reg);
                    state_next         = ST_IDLE;
                end
            end
            ST_KILL:
            begin
                // Uncommitted entries never hold LF, so the run ends at the commit point
                if (can_emit)
                begin
                    edit_ptr_next      = edit_dec;
                    emit               = 1'b1;
                    emit_data.out_kind = KIND_ERASE;
                    emit_data.last     = (edit_dec == commit_ptr_reg);
                    if (edit_dec == commit_ptr_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            read_ptr_reg   <= '0;
            commit_ptr_reg <= '0;
            edit_ptr_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            read_ptr_reg   <= read_ptr_next;
            commit_ptr_reg <= commit_ptr_next;
            edit_ptr_reg   <= edit_ptr_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_reg <= emit_data;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Fill never exceeds the buffer, and the edited line lies inside it
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= FILL_W'(BUFFER_DEPTH))
        else $error("fill level beyond buffer depth");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending <= fill)
        else $error("edit region outside filled region");

    a_kill_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KILL) |-> (edit_ptr_reg != commit_ptr_reg))
        else $error("kill run with nothing left to erase");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD_WAIT) |=> (state_reg == ST_RD_EMIT))
        else $error("read data not picked up after RAM latency");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |-> !emit)
        else $error("result register overwritten while stalled");

endmodule

// ===== src/console_line_editor.sv =====
// Channel | Direction | Handshake            | Beat
// req     | in        | req_valid/req_stall  | cle_in_t  {req_type, char_in}
// rsp     | out       | rsp_valid/rsp_stall  | cle_out_t {out_kind, out_char, is_eof,
//         |           |                      |            line_committed, last}
//
// Sequencing: echo, erase, process-list and empty read finish in ST_IDLE; a character
//   read passes ST_RD_WAIT and ST_RD_EMIT (RAM registered read); kill line, in ST_KILL,
//   erases one character per step. The back end handles one queued command at a time.
// Reset: rst_n asynchronous, clears pointers, state and queue; line store left unset.
// Stalls: a stalled result holds in the output register; the back end stops, the queue
//   fills, and req_stall rises once it is full.
module console_line_editor #(
    parameter int BUFFER_DEPTH = 64,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  cle_pkg::cle_in_t  req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output cle_pkg::cle_out_t rsp
);

    import cle_pkg::*;

    localparam int IDX_W = $clog2(BUFFER_DEPTH);

    // front -> queue
    logic       q_full;
    logic       q_push;
    cle_entry_t push_entry;

    // queue -> back
    logic       q_valid;
    logic       q_pop;
    cle_entry_t q_entry;

    // back <-> line store
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
    logic [7:0]       rdata;

    // Classifier: maps a request beat to a command, maps CR to LF, drops NUL
    cle_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    // Short command queue decoupling intake from execution
    cle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .pop        (q_pop),
        .q_entry    (q_entry)
    );

    // Executor: ring pointers, line store access, result register
    cle_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .we        (we),
        .waddr     (waddr),
        .wdata     (wdata),
        .re        (re),
        .raddr     (raddr),
        .rdata     (rdata),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // Line store
    cle_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

endmodule
